[hdl/rsq_pkg.sv]
// Shared types, constants and helpers of the tracker row sequencer.
package rsq_pkg;

  // Fixed-point layout of the row timing
  localparam int FRAC_BITS = 16;
  localparam int TPR_W     = FRAC_BITS + 8;
  localparam int ACC_W     = FRAC_BITS + 9;

  // 150 * speed fits in 13 bits for any 5-bit speed
  localparam int SCALE_W = 13;
  localparam int NUM_W   = SCALE_W + FRAC_BITS;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam int SPEED_W = 5;
  localparam int TEMPO_W = 8;
  localparam int LEN_W   = 9;
  localparam int POS_W   = 8;
  localparam int EVT_W   = 32;
  localparam int DVR_W   = 9;
  localparam int CFG_W   = 9;

  localparam logic [SCALE_W-1:0] ROW_SCALE = SCALE_W'(150);
  localparam logic [POS_W-1:0]   TEMPO_MIN = POS_W'(32);
  localparam logic [ACC_W:0]     ACC_UNIT  = (ACC_W + 1)'(1) << FRAC_BITS;

  localparam logic [SPEED_W-1:0] RST_SPEED = SPEED_W'(6);
  localparam logic [TEMPO_W-1:0] RST_TEMPO = TEMPO_W'(150);
  localparam logic [LEN_W-1:0]   RST_PLEN  = LEN_W'(64);
  localparam logic [LEN_W-1:0]   RST_FCNT  = LEN_W'(1);

  // Divider runs: full quotient for the row period, short run for frame wrap
  localparam logic [STEP_W-1:0] STEPS_TPR = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] STEPS_MOD = STEP_W'(LEN_W);

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SPEED = 3'd3,
    CMD_JUMP  = 3'd4,
    CMD_SKIP  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_INIT_SPEED = 2'd0,
    REG_INIT_TEMPO = 2'd1,
    REG_PAT_LEN    = 2'd2,
    REG_FRAME_CNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_EVT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [DVR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TPR_W-1:0]  quot;
    logic [DVR_W-1:0]  rem;
  } div_rsp_t;

  // Length register as used: zero acts as one, above 256 as 256
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(256)) r = LEN_W'(256);
    return r;
  endfunction

  // Next frame, wrapping to zero at the frame count, when the current one is below it
  function automatic logic [POS_W-1:0] adv_frame(input logic [POS_W-1:0] f,
                                                 input logic [LEN_W-1:0] fc);
    logic [LEN_W-1:0] n;
    n = {1'b0, f} + LEN_W'(1);
    return (n == fc) ? '0 : n[POS_W-1:0];
  endfunction

endpackage

[hdl/tracker_row_sequencer.sv]
// Top level of the tracker row sequencer: command decode, row timing, event output.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser command, tdata value
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata frame,row,event, tlast
//  cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One command at a time. Stop, jump, a skip within the frame count and a tick with no row
// due complete at acceptance. A tick with row events waits until each event is taken.
// Start and speed/tempo run the bit-serial divider for the row period. A frame step from
// a frame at or above the frame count first runs the divider as a modulo unit.
// Reset is synchronous; cfg is always ready.
// A stalled m_axis holds the event; no new command is taken until all events are out.
module tracker_row_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  // s_axis
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] value
  input  logic [2:0]                s_axis_tuser,   // [2:0] command
  // m_axis
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,   // [7:0] frame_index, [15:8] row_index,
                                                    // [47:16] event_number
  output logic                      m_axis_tlast,   // last
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [rsq_pkg::CFG_W-1:0] cfg_data
);
  import rsq_pkg::*;

  // Configuration registers
  logic [SPEED_W-1:0] init_speed;
  logic [TEMPO_W-1:0] init_tempo;
  logic [LEN_W-1:0]   pat_len;
  logic [LEN_W-1:0]   frame_cnt;

  // Sequencer state
  state_t             state, state_next;
  logic [SPEED_W-1:0] speed;
  logic [TEMPO_W-1:0] tempo;
  logic [TPR_W-1:0]   tpr;
  logic [ACC_W-1:0]   acc;
  logic [POS_W-1:0]   frame;
  logic [POS_W-1:0]   row;
  logic [EVT_W-1:0]   count;
  logic               playing;
  logic               cont_skip;
  logic [POS_W-1:0]   skip_val;

  // Output register
  logic [POS_W-1:0]   out_frame;
  logic [POS_W-1:0]   out_row;
  logic [EVT_W-1:0]   out_count;
  logic               out_last;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Decode and helpers
  cmd_t               cmd;
  logic [POS_W-1:0]   val;
  logic               in_hs, out_hs;
  logic [LEN_W-1:0]   pl_eff, fc_eff;
  logic               frame_ok;
  logic               acc_ge;
  logic [ACC_W-1:0]   acc_sub;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_inc;
  logic [LEN_W-1:0]   row_inc;
  logic               row_wrap;
  logic               ev_load, ev_mod;
  logic               tick_due;
  logic               rec_start, mod_start;
  logic [SPEED_W-1:0] speed_new;
  logic [TEMPO_W-1:0] tempo_new;
  logic [SCALE_W-1:0] scaled;
  logic [POS_W-1:0]   skip_f1;
  logic [POS_W-1:0]   mod_f1;

  assign cmd    = cmd_t'(s_axis_tuser);
  assign val    = s_axis_tdata;
  assign in_hs  = s_axis_tvalid && s_axis_tready;
  assign out_hs = m_axis_tvalid && m_axis_tready;
  assign cfg_ready = 1'b1;

  // Arithmetic on the row timing and positions
  always_comb begin
    pl_eff   = eff_len(pat_len);
    fc_eff   = eff_len(frame_cnt);
    frame_ok = {1'b0, frame} < fc_eff;
    acc_ge   = acc >= {1'b0, tpr};
    acc_sub  = acc - {1'b0, tpr};
    acc_sum  = {1'b0, acc} + ACC_UNIT;
    acc_inc  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    row_inc  = {1'b0, row} + LEN_W'(1);
    row_wrap = row_inc >= pl_eff;
    skip_f1  = adv_frame(frame, fc_eff);
    mod_f1   = div_rsp.rem[POS_W-1:0];
  end

  // Row event loads: first of a tick, or the second once the first is taken
  always_comb begin
    tick_due = (state == ST_IDLE) && in_hs && (cmd == CMD_TICK) && playing && acc_ge;
    ev_load  = tick_due || ((state == ST_EVT) && out_hs && !out_last);
    ev_mod   = ev_load && row_wrap && !frame_ok;
  end

  // New speed and tempo for a recompute
  always_comb begin
    speed_new = speed;
    tempo_new = tempo;
    if (cmd == CMD_START) begin
      tempo_new = init_tempo;
      speed_new = (init_speed == '0) ? SPEED_W'(1) : init_speed;
    end else if (val >= TEMPO_MIN) begin
      tempo_new = val;
    end else begin
      speed_new = (val[SPEED_W-1:0] == '0) ? SPEED_W'(1) : val[SPEED_W-1:0];
    end
    scaled = ROW_SCALE * SCALE_W'(speed_new);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_hs) begin
          unique case (cmd)
            CMD_START, CMD_SPEED: state_next = ST_DIV;
            CMD_TICK: begin
              if (tick_due) state_next = ev_mod ? ST_MOD : ST_EVT;
            end
            CMD_SKIP: begin
              if (!frame_ok) state_next = ST_MOD;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_IDLE;
      end
      ST_MOD: begin
        if (div_rsp.done) state_next = cont_skip ? ST_IDLE : ST_EVT;
      end
      ST_EVT: begin
        if (out_hs) begin
          if (out_last) state_next = ST_IDLE;
          else if (ev_mod) state_next = ST_MOD;
        end
      end
    endcase
  end

  // Outputs of the state machine and divider requests
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_EVT);
    rec_start = (state == ST_IDLE) && in_hs && ((cmd == CMD_START) || (cmd == CMD_SPEED));
    mod_start = ev_mod ||
                ((state == ST_IDLE) && in_hs && (cmd == CMD_SKIP) && !frame_ok);
    div_req.start = rec_start || mod_start;
    if (mod_start) begin
      div_req.dividend = {({1'b0, frame} + LEN_W'(1)), (NUM_W - LEN_W)'(0)};
      div_req.divisor  = fc_eff;
      div_req.steps    = STEPS_MOD;
    end else begin
      div_req.dividend = {scaled, FRAC_BITS'(0)};
      div_req.divisor  = {1'b0, tempo_new};
      div_req.steps    = STEPS_TPR;
    end
  end

  rsq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_speed <= RST_SPEED;
      init_tempo <= RST_TEMPO;
      pat_len    <= RST_PLEN;
      frame_cnt  <= RST_FCNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INIT_SPEED: init_speed <= cfg_data[SPEED_W-1:0];
        REG_INIT_TEMPO: init_tempo <= cfg_data[TEMPO_W-1:0];
        REG_PAT_LEN:    pat_len    <= cfg_data[LEN_W-1:0];
        REG_FRAME_CNT:  frame_cnt  <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  // Sequencer state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      speed     <= RST_SPEED;
      tempo     <= RST_TEMPO;
      tpr       <= '0;
      acc       <= '0;
      frame     <= '0;
      row       <= '0;
      count     <= '0;
      playing   <= 1'b0;
      cont_skip <= 1'b0;
      skip_val  <= '0;
      out_last  <= 1'b0;
    end else begin
      state <= state_next;

      // Command effects at acceptance
      if ((state == ST_IDLE) && in_hs) begin
        unique case (cmd)
          CMD_TICK: begin
            if (playing && !acc_ge) acc <= acc_inc;
          end
          CMD_START: begin
            speed   <= speed_new;
            tempo   <= tempo_new;
            playing <= 1'b1;
            count   <= '0;
            row     <= '0;
          end
          CMD_STOP: begin
            playing <= 1'b0;
            acc     <= '0;
          end
          CMD_SPEED: begin
            speed <= speed_new;
            tempo <= tempo_new;
          end
          CMD_JUMP: begin
            frame <= ({1'b0, val} >= fc_eff) ? '0 : val;
            row   <= '0;
          end
          CMD_SKIP: begin
            cont_skip <= 1'b1;
            skip_val  <= val;
            if (frame_ok) begin
              if ({1'b0, val} >= pl_eff) begin
                frame <= adv_frame(skip_f1, fc_eff);
                row   <= '0;
              end else begin
                frame <= skip_f1;
                row   <= val;
              end
            end
          end
          default: ;
        endcase
      end

      // Row event: report, then step the row
      if (ev_load) begin
        out_last  <= tick_due ? (acc_sub < {1'b0, tpr}) : 1'b1;
        count     <= count + EVT_W'(1);
        acc       <= acc_sub;
        cont_skip <= 1'b0;
        if (row_wrap) begin
          row <= '0;
          if (frame_ok) frame <= skip_f1;
        end else begin
          row <= row_inc[POS_W-1:0];
        end
      end

      // Final event of the tick taken: add one tick
      if ((state == ST_EVT) && out_hs && out_last) acc <= acc_inc;

      // Recompute finished
      if ((state == ST_DIV) && div_rsp.done) begin
        tpr <= div_rsp.quot;
        acc <= {1'b0, div_rsp.quot};
      end

      // Frame modulo finished
      if ((state == ST_MOD) && div_rsp.done) begin
        if (cont_skip && ({1'b0, skip_val} >= pl_eff)) begin
          frame <= adv_frame(mod_f1, fc_eff);
          row   <= '0;
        end else if (cont_skip) begin
          frame <= mod_f1;
          row   <= skip_val;
        end else begin
          frame <= mod_f1;
        end
      end
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    if (ev_load) begin
      out_frame <= frame;
      out_row   <= row;
      out_count <= count + EVT_W'(1);
    end
  end

  assign m_axis_tdata = {out_count, out_row, out_frame};
  assign m_axis_tlast = out_last;

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while an event is pending");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV || state == ST_MOD))
    else $error("divider finished outside a divider run");

  a_evt_playing: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> playing)
    else $error("row event while stopped");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after final event of a tick");

endmodule

[hdl/rsq_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, saturating quotient.
module rsq_div (
  input  logic              clk,
  input  logic              rst,
  input  rsq_pkg::div_req_t req,
  output rsq_pkg::div_rsp_t rsp
);
  import rsq_pkg::*;

  logic [NUM_W-1:0]  dvd;
  logic [DVR_W-1:0]  dvr;
  logic [DVR_W-1:0]  rem;
  logic [TPR_W-1:0]  quot;
  logic              ovf;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DVR_W:0]    trial;
  logic [DVR_W:0]    diff;
  logic              ge;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem, dvd[NUM_W-1]};
    ge    = trial >= {1'b0, dvr};
    diff  = trial - {1'b0, dvr};
  end

  // Control: run counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dvr  <= req.divisor;
      rem  <= '0;
      quot <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      dvd  <= {dvd[NUM_W-2:0], 1'b0};
      rem  <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
      quot <= {quot[TPR_W-2:0], ge};
      ovf  <= ovf | quot[TPR_W-1];
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = ovf ? '1 : quot;
    rsp.rem  = rem;
  end

endmodule

[verif/tb.sv]
// Testbench of tracker_row_sequencer: directed command table, then randomized play phases.
`timescale 1ns / 1ps

module tb;
  import rsq_pkg::*;

  // Commands the block ignores
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  localparam logic [63:0] PERIOD_MAX  = (64'd1 << TPR_W) - 64'd1;
  localparam logic [ACC_W:0] ACC_TOP  = {1'b0, {ACC_W{1'b1}}};
  localparam int          ROW_SCALE_C = 150;
  localparam int          TEMPO_FLOOR = 32;
  localparam int          SETTLE      = 64;   // divider run plus frame modulo, with margin
  localparam int          QUIET_LIMIT = 4000;
  localparam int          PHASE_ITEMS = 75;
  localparam int          N_PHASES    = 7;

  typedef struct packed {
    logic [7:0]  frame_idx;
    logic [7:0]  row_idx;
    logic [31:0] seq_no;
    logic        is_last;
  } row_event_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] val;
    logic       typed;
    logic [1:0] n;
    row_event_t ev;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  tracker_row_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sequencer shadow: registers and playback state
  logic [4:0]       cfg_speed = 5'd6;
  logic [7:0]       cfg_tempo = 8'd150;
  logic [8:0]       cfg_plen  = 9'd64;
  logic [8:0]       cfg_fcnt  = 9'd1;
  logic [4:0]       cur_speed = 5'd6;
  logic [7:0]       cur_tempo = 8'd150;
  logic [TPR_W-1:0] row_period = '0;
  logic [ACC_W-1:0] tick_acc = '0;
  logic [7:0]       frame_pos = '0;
  logic [7:0]       row_pos = '0;
  logic [31:0]      events_played = '0;
  logic             running = 1'b0;

  row_event_t fresh_events[$];
  row_event_t due_events[$];
  stim_row_t  dir_rows[$];

  int err_count = 0;
  int sent = 0;
  int quiet_cycles = 0;
  int sink_hold = 0;
  int sink_gap;
  logic [31:0] cyc = '0;

  // Length register as used
  function automatic logic [8:0] usable_len(input logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

  // Row period = 150 * speed / tempo in fixed point, saturating; also reloads the accumulator
  function automatic void reload_period();
    logic [63:0] num;
    logic [63:0] q;
    num = (64'(ROW_SCALE_C) * 64'(cur_speed)) << FRAC_BITS;
    q = PERIOD_MAX;
    if (cur_tempo != 8'd0) begin
      q = num / 64'(cur_tempo);
      if (q > PERIOD_MAX) q = PERIOD_MAX;
    end
    row_period = q[TPR_W-1:0];
    tick_acc = ACC_W'(q);
  endfunction

  function automatic void apply_speed(input logic [7:0] v);
    if (v < 8'd1) v = 8'd1;
    cur_speed = v[4:0];
    reload_period();
  endfunction

  function automatic void bump_frame(input logic [7:0] new_row);
    logic [8:0] f;
    logic [8:0] fc;
    fc = usable_len(cfg_fcnt);
    f = {1'b0, frame_pos} + 9'd1;
    if (f >= fc) f = f % fc;
    frame_pos = f[7:0];
    row_pos = new_row;
  endfunction

  function automatic void step_row();
    logic [8:0] r;
    r = {1'b0, row_pos} + 9'd1;
    if (r >= usable_len(cfg_plen)) bump_frame(8'd0);
    else row_pos = r[7:0];
  endfunction

  // Applies one command to the shadow state; row events go to fresh_events
  function automatic void play_command(input logic [2:0] cmd, input logic [7:0] val);
    row_event_t ev;
    logic [ACC_W:0] sum;
    int n;
    case (cmd)
      CMD_TICK: begin
        if (running) begin
          n = 0;
          while (n < 2 && tick_acc >= ACC_W'(row_period)) begin
            ev.frame_idx = frame_pos;
            ev.row_idx = row_pos;
            events_played = events_played + 32'd1;
            ev.seq_no = events_played;
            step_row();
            tick_acc = tick_acc - ACC_W'(row_period);
            n++;
            ev.is_last = (n == 2) || (tick_acc < ACC_W'(row_period));
            fresh_events.push_back(ev);
          end
          sum = {1'b0, tick_acc} + ((ACC_W + 1)'(1) << FRAC_BITS);
          if (sum > ACC_TOP) sum = ACC_TOP;
          tick_acc = sum[ACC_W-1:0];
        end
      end
      CMD_START: begin
        cur_tempo = cfg_tempo;
        apply_speed({3'b0, cfg_speed});
        running = 1'b1;
        events_played = '0;
        row_pos = '0;
      end
      CMD_STOP: begin
        running = 1'b0;
        tick_acc = '0;
      end
      CMD_SPEED: begin
        if (val >= 8'(TEMPO_FLOOR)) begin
          cur_tempo = val;
          reload_period();
        end else begin
          apply_speed(val);
        end
      end
      CMD_JUMP: begin
        frame_pos = ({1'b0, val} >= usable_len(cfg_fcnt)) ? 8'd0 : val;
        row_pos = '0;
      end
      CMD_SKIP: begin
        bump_frame(8'd0);
        if ({1'b0, val} >= usable_len(cfg_plen)) bump_frame(8'd0);
        else row_pos = val;
      end
      default: begin
      end
    endcase
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic add_plain(input logic [2:0] c, input logic [7:0] v);
    stim_row_t s;
    s = '0;
    s.cmd = c;
    s.val = v;
    dir_rows.push_back(s);
  endtask

  task automatic add_typed(input logic [2:0] c, input logic [7:0] v, input logic [1:0] n,
                           input logic [7:0] f, input logic [7:0] r, input logic [31:0] q,
                           input logic l);
    stim_row_t s;
    s.cmd = c;
    s.val = v;
    s.typed = 1'b1;
    s.n = n;
    s.ev = '{f, r, q, l};
    dir_rows.push_back(s);
  endtask

  // One command transaction; expectations are queued at acceptance
  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] val, input logic typed,
                          input logic [1:0] typed_n, input row_event_t typed_ev);
    int gap;
    gap = (((sent / 48) % 4) == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= val;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    fresh_events.delete();
    play_command(cmd, val);
    if (typed) begin
      if (typed_n != 2'd0) due_events.push_back(typed_ev);
    end else begin
      foreach (fresh_events[k]) due_events.push_back(fresh_events[k]);
    end
  endtask

  // Hold off commands until every pending row event has come out
  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INIT_SPEED: cfg_speed = data[4:0];
      REG_INIT_TEMPO: cfg_tempo = data[7:0];
      REG_PAT_LEN:    cfg_plen = data[8:0];
      REG_FRAME_CNT:  cfg_fcnt = data[8:0];
      default: begin
      end
    endcase
  endtask

  // Random command, weighted toward ticks
  task automatic pick_command(output logic [2:0] cmd, output logic [7:0] val);
    int r;
    r = $urandom_range(0, 99);
    val = 8'($urandom_range(0, 255));
    if (r < 55) begin
      cmd = CMD_TICK;
    end else if (r < 60) begin
      cmd = CMD_START;
    end else if (r < 63) begin
      cmd = CMD_STOP;
    end else if (r < 75) begin
      cmd = CMD_SPEED;
      r = $urandom_range(0, 99);
      if (r < 50) val = 8'($urandom_range(0, 7));
      else if (r < 65) val = 8'($urandom_range(8, 31));
    end else if (r < 84) begin
      cmd = CMD_JUMP;
      if ($urandom_range(0, 1) == 0) val = 8'($urandom_range(0, 15));
    end else if (r < 95) begin
      cmd = CMD_SKIP;
      if ($urandom_range(0, 9) < 6) val = 8'($urandom_range(0, usable_len(cfg_plen) - 1));
    end else begin
      cmd = ($urandom_range(0, 1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7;
    end
  endtask

  // Result sink with random stalls; no new stall starts while cyc[9:8] is 3
  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      sink_gap = (cyc[9:8] == 2'b11 || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      if (sink_gap > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold <= sink_gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Row event check against the oldest pending expectation
  always @(posedge clk) begin : event_check
    row_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_events.size() == 0) begin
        flag_error($sformatf("row event with none pending: frame %0d row %0d seq %0d",
                             m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[47:16]));
      end else begin
        want = due_events.pop_front();
        if (m_axis_tdata[7:0] !== want.frame_idx)
          flag_error($sformatf("seq %0d frame_index got %0d want %0d", want.seq_no,
                               m_axis_tdata[7:0], want.frame_idx));
        if (m_axis_tdata[15:8] !== want.row_idx)
          flag_error($sformatf("seq %0d row_index got %0d want %0d", want.seq_no,
                               m_axis_tdata[15:8], want.row_idx));
        if (m_axis_tdata[47:16] !== want.seq_no)
          flag_error($sformatf("event_number got %0d want %0d", m_axis_tdata[47:16],
                               want.seq_no));
        if (m_axis_tlast !== want.is_last)
          flag_error($sformatf("seq %0d last got %b want %b", want.seq_no, m_axis_tlast,
                               want.is_last));
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("ERROR @%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned ph_speed[6] = '{1, 31, 0, 17, 3, 6};
    int unsigned ph_tempo[6] = '{255, 32, 0, 200, 96, 150};
    int unsigned ph_plen[6]  = '{1, 256, 0, 300, 5, 4};
    int unsigned ph_fcnt[6]  = '{256, 1, 0, 511, 7, 2};
    logic [2:0] cmd;
    logic [7:0] val;
    int         counted;

    // Directed part, from reset defaults
    add_typed(CMD_TICK,   8'h00, 2'd0, 8'd0, 8'd0, 32'd0, 1'b0);  // stopped: no event
    add_typed(CMD_RSVD_6, 8'hFF, 2'd0, 8'd0, 8'd0, 32'd0, 1'b0);
    add_typed(CMD_RSVD_7, 8'h00, 2'd0, 8'd0, 8'd0, 32'd0, 1'b0);
    add_typed(CMD_START,  8'hFF, 2'd0, 8'd0, 8'd0, 32'd0, 1'b0);
    add_typed(CMD_TICK,   8'h00, 2'd1, 8'd0, 8'd0, 32'd1, 1'b1);  // first row right away
    add_typed(CMD_TICK,   8'hFF, 2'd0, 8'd0, 8'd0, 32'd0, 1'b0);
    add_plain(CMD_SPEED,  8'd0);                                   // speed 0 clamps to 1
    add_typed(CMD_TICK,   8'h00, 2'd1, 8'd0, 8'd1, 32'd2, 1'b1);
    add_typed(CMD_TICK,   8'h00, 2'd1, 8'd0, 8'd2, 32'd3, 1'b1);
    add_plain(CMD_SPEED,  8'd255);                                 // shortest row period
    add_plain(CMD_TICK,   8'h00);
    add_plain(CMD_TICK,   8'h00);
    add_plain(CMD_TICK,   8'h00);                                  // two events in one tick
    add_plain(CMD_JUMP,   8'd255);                                 // beyond frame count
    add_plain(CMD_SKIP,   8'd255);                                 // row beyond pattern
    add_plain(CMD_SKIP,   8'd0);
    add_plain(CMD_SKIP,   8'd63);                                  // last row of pattern
    add_plain(CMD_TICK,   8'h00);
    add_plain(CMD_TICK,   8'h00);
    add_plain(CMD_SPEED,  8'd32);                                  // lowest tempo
    add_plain(CMD_SPEED,  8'd31);                                  // highest speed
    add_plain(CMD_TICK,   8'h00);
    add_plain(CMD_STOP,   8'h00);
    add_typed(CMD_TICK,   8'h00, 2'd0, 8'd0, 8'd0, 32'd0, 1'b0);
    add_plain(CMD_SPEED,  8'd6);                                   // speed change while stopped

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].n,
               dir_rows[i].ev);

    // Random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      drain(SETTLE);
      if (p < 6) begin
        cfg_write(REG_INIT_SPEED, CFG_W'(ph_speed[p]));
        cfg_write(REG_INIT_TEMPO, CFG_W'(ph_tempo[p]));
        cfg_write(REG_PAT_LEN,    CFG_W'(ph_plen[p]));
        cfg_write(REG_FRAME_CNT,  CFG_W'(ph_fcnt[p]));
      end else begin
        cfg_write(REG_INIT_SPEED, CFG_W'($urandom_range(0, 31)));
        cfg_write(REG_INIT_TEMPO, CFG_W'($urandom_range(0, 255)));
        cfg_write(REG_PAT_LEN,    CFG_W'($urandom_range(1, 16)));
        cfg_write(REG_FRAME_CNT,  CFG_W'($urandom_range(1, 16)));
      end
      cfg_valid <= 1'b0;
      send_cmd(CMD_START, 8'($urandom_range(0, 255)), 1'b0, 2'd0, '0);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick_command(cmd, val);
        send_cmd(cmd, val, 1'b0, 2'd0, '0);
        counted++;
        if ($urandom_range(0, 39) == 0) drain(0);
      end
    end

    drain(SETTLE);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rsq_pkg.sv
hdl/rsq_div.sv
hdl/tracker_row_sequencer.sv
verif/tb.sv
